>>> hdl/sha256_stream_hasher_macros.svh
// Assertion macros for the SHA-256 stream hasher checker
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// implication checked on every clock, suppressed during reset
`define SHA_ASSERT_IMP(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);
`endif

>>> hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef logic [31:0] word_type;

   // one queued input beat, as the back end sees it
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       message_end;
   } beat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUNDS,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam word_type INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_MARK     = 8'h80;
   localparam logic [5:0] LEN_POS      = 6'd56;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic word_type big_sig0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type sml_sig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type sml_sig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage

>>> hdl/sha_stream_if.sv
// ----------------------------------------------------------------------------
// sha_req_if / sha_rsp_if
// Valid/ready channels for input beats and digest words.
// ----------------------------------------------------------------------------
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       message_end;
   modport source (output valid, data_byte, byte_valid, message_end, input ready);
   modport sink   (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hdl/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts input beats, drops empty ones and queues the rest (two entries).
// ----------------------------------------------------------------------------
module sha_front (
   input  logic              clock,
   input  logic              reset,
   sha_req_if.sink           req,
   output sha_pkg::beat_type q_beat,
   output logic              q_valid,
   input  logic              q_take
);
   import sha_pkg::*;

   beat_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push;
   logic       pop;

   assign req.ready = (count_ff != 2'd2);
   // beats with neither a byte nor an end carry no work
   assign push      = req.valid && req.ready && (req.byte_valid || req.message_end);
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_take && q_valid;
   assign q_beat    = slot_ff[rd_ptr_ff];

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{data_byte: req.data_byte, byte_valid: req.byte_valid,
                                 message_end: req.message_end};
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

>>> hdl/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Message schedule, padding, 64-round compression and digest output.
// ----------------------------------------------------------------------------
module sha_back (
   input  logic              clock,
   input  logic              reset,
   input  sha_pkg::beat_type q_beat,
   input  logic              q_valid,
   output logic              q_take,
   sha_rsp_if.source         rsp
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   word_type   h_ff [8];
   word_type   v_ff [8];
   word_type   w_ff [16];
   logic [63:0] bits_ff;
   logic [63:0] len_ff;
   logic [5:0] rnd_ff;
   logic [5:0] pad_ff;
   logic       final_ff;    // this compression ends the message
   logic       fin_pend_ff; // marker already placed, length block still to do
   logic       end_wait_ff; // message end waits behind a full data block
   logic [2:0] out_idx_ff;
   logic [2:0] fold_ff;

   logic [5:0] pos;
   logic       start_cmp;
   logic       blk_wr;
   logic [5:0] blk_addr;
   logic [7:0] blk_data;
   word_type   t1, t2, w_new, w_cur;

   assign pos   = bits_ff[8:3];
   assign w_cur = w_ff[0];
   assign t1 = v_ff[7] + big_sig1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + ROUND_K[rnd_ff] + w_cur;
   assign t2 = big_sig0(v_ff[0]) + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2])
             ^ (v_ff[1] & v_ff[2]));
   assign w_new = sml_sig1(w_ff[14]) + w_ff[9] + sml_sig0(w_ff[1]) + w_ff[0];

   assign rsp.valid       = (state_ff == ST_EMIT);
   assign rsp.digest_word = h_ff[out_idx_ff];
   assign rsp.word_index  = out_idx_ff;
   assign rsp.last_word   = (out_idx_ff == 3'd7);

   // next state, block byte write and queue pop
   always_comb begin
      state_in  = state_ff;
      q_take    = 1'b0;
      start_cmp = 1'b0;
      blk_wr    = 1'b0;
      blk_addr  = pos;
      blk_data  = q_beat.data_byte;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_take = 1'b1;
               if (q_beat.byte_valid) begin
                  blk_wr = 1'b1;
                  if (pos == 6'd63) begin
                     start_cmp = 1'b1;
                     state_in  = ST_ROUNDS;
                  end else if (q_beat.message_end) begin
                     state_in = ST_PAD;
                  end
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // one byte a cycle: marker, zeros, length in the block that carries it
            blk_wr   = 1'b1;
            blk_addr = pad_ff;
            if (pad_ff >= LEN_POS && (fin_pend_ff || pos < LEN_POS))
               blk_data = len_ff[{~pad_ff[2:0], 3'b111} -: 8];
            else
               blk_data = 8'h00;
            if (pad_ff == pos && !fin_pend_ff) blk_data = PAD_MARK;
            if (pad_ff == 6'd63) begin
               start_cmp = 1'b1;
               state_in  = ST_ROUNDS;
            end
         end
         ST_ROUNDS: begin
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (fold_ff == 3'd7)
               state_in = final_ff ? ST_EMIT
                        : ((fin_pend_ff || end_wait_ff) ? ST_PAD : ST_IDLE);
         end
         ST_EMIT: begin
            if (rsp.ready && out_idx_ff == 3'd7) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // message schedule and working variables
   always_ff @(posedge clock) begin
      if (state_ff == ST_ROUNDS) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end else begin
         // block bytes land big-endian in the schedule words
         if (blk_wr) w_ff[blk_addr[5:2]][{~blk_addr[1:0], 3'b000} +: 8] <= blk_data;
         if (start_cmp) begin
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end
      end
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         bits_ff     <= '0;
         rnd_ff      <= '0;
         pad_ff      <= '0;
         final_ff    <= 1'b0;
         fin_pend_ff <= 1'b0;
         end_wait_ff <= 1'b0;
         out_idx_ff  <= '0;
         fold_ff     <= '0;
         len_ff      <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  logic [63:0] nb;
                  nb = bits_ff + (q_beat.byte_valid ? 64'd8 : 64'd0);
                  bits_ff <= nb;
                  len_ff  <= nb;
                  pad_ff  <= nb[8:3];
                  fin_pend_ff <= 1'b0;
                  end_wait_ff <= q_beat.message_end && q_beat.byte_valid && pos == 6'd63;
                  final_ff    <= 1'b0;
               end
            end
            ST_PAD: begin
               pad_ff      <= pad_ff + 6'd1;
               end_wait_ff <= 1'b0;
               if (pad_ff == 6'd63) begin
                  // marker plus length fit only below byte 56
                  final_ff    <= fin_pend_ff || pos < LEN_POS;
                  fin_pend_ff <= !(fin_pend_ff || pos < LEN_POS);
                  if (!(fin_pend_ff || pos < LEN_POS)) begin
                     pad_ff <= 6'd0;
                  end
               end
            end
            ST_ROUNDS: begin
               rnd_ff <= rnd_ff + 6'd1;
               fold_ff <= '0;
            end
            ST_FOLD: begin
               h_ff[fold_ff] <= h_ff[fold_ff] + v_ff[fold_ff];
               fold_ff <= fold_ff + 3'd1;
               if (fold_ff == 3'd7 && fin_pend_ff && !final_ff) pad_ff <= 6'd0;
            end
            ST_EMIT: begin
               if (rsp.ready) begin
                  out_idx_ff <= out_idx_ff + 3'd1;
                  if (out_idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= INIT_H[i];
                     bits_ff     <= '0;
                     final_ff    <= 1'b0;
                     fin_pend_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end
endmodule

>>> hdl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Byte beats pass a two-entry queue and are written straight into the message
// schedule, one per cycle while the back end is idle, until a block fills;
// each 64-byte block then runs the 64 rounds of the single round unit and is
// folded word by word into the chaining value, and no beat is taken meanwhile.
// Beats with neither a byte nor an end are dropped at the queue. Message end
// adds a padding sweep, one byte per cycle, from the marker to the end of
// the block (a whole block when the length needs a second one), the
// compressions, and eight digest beats on the result channel. The input
// stalls once the queue holds two beats.
module sha256_stream_hasher (
   input logic       clock,
   input logic       reset,
   sha_req_if.sink   req,
   sha_rsp_if.source rsp
);
   import sha_pkg::*;

   beat_type q_beat;
   logic     q_valid;
   logic     q_take;

   sha_front u_front (
      .clock (clock), .reset (reset), .req (req),
      .q_beat (q_beat), .q_valid (q_valid), .q_take (q_take)
   );

   sha_back u_back (
      .clock (clock), .reset (reset),
      .q_beat (q_beat), .q_valid (q_valid), .q_take (q_take), .rsp (rsp)
   );
endmodule

>>> hdl/sha_checker.sv
// ----------------------------------------------------------------------------
// sha_checker
// Port-level checks for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
`include "sha256_stream_hasher_macros.svh"
module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word,
   input logic [31:0] rsp_digest_word
);
   // last flag marks word seven only
   `SHA_ASSERT_IMP(a_last, clock, reset, rsp_valid, rsp_last_word == (rsp_word_index == 3'd7), "last flag mismatch")
   // word index advances by one within a digest
   `SHA_ASSERT_NEXT(a_step, clock, reset, rsp_valid && rsp_ready && !rsp_last_word, rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1, "digest words not contiguous")
   // stalled beat holds
   `SHA_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_digest_word), "stalled word changed")
endmodule

bind sha256_stream_hasher sha_checker u_checker (
   .clock (clock), .reset (reset),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_word_index (rsp.word_index), .rsp_last_word (rsp.last_word),
   .rsp_digest_word (rsp.digest_word)
);
